// ===== design/casu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package casu_pkg;

  localparam int CMD_W    = 3;
  localparam int DEG_W    = 11;
  localparam int COOKIE_W = 8;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 4;
  localparam int CNT_W    = 4;

  localparam logic [CMD_W-1:0] CMD_INIT     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REGISTER = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SETPOS   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ACK      = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 4'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 4'd1;
  localparam logic [STATUS_W-1:0] ST_TAKEN   = 4'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 4'd3;
  localparam logic [STATUS_W-1:0] ST_POS     = 4'd4;
  localparam logic [STATUS_W-1:0] ST_SYNC    = 4'd5;
  localparam logic [STATUS_W-1:0] ST_OVERRUN = 4'd6;
  localparam logic [STATUS_W-1:0] ST_NONE    = 4'd7;
  localparam logic [STATUS_W-1:0] ST_HALTED  = 4'd8;

  typedef struct packed {
    logic capture;
    logic multiply;
    logic execute;
    logic fetch;
    logic load_out;
  } casu_ctrl_t;

  typedef struct packed {
    logic ack_hit;
  } casu_stat_t;

endpackage
`default_nettype wire

// ===== design/casu_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module casu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 72
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ===== design/casu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module casu_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  input  wire casu_pkg::casu_stat_t stat,
  output casu_pkg::casu_ctrl_t     ctrl
);
  import casu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_EXEC,
    S_FETCH,
    S_PUSH
  } state_t;

  state_t state_r;
  logic   in_ready_r;
  logic   out_valid_r;

  assign in_ready  = in_ready_r;
  assign out_valid = out_valid_r;

  always_comb begin
    ctrl          = '0;
    ctrl.capture  = in_ready_r && in_valid;
    ctrl.multiply = (state_r == S_MUL);
    ctrl.execute  = (state_r == S_EXEC);
    ctrl.fetch    = (state_r == S_FETCH);
    ctrl.load_out = (state_r == S_PUSH) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (ctrl.capture) begin
            state_r    <= S_MUL;
            in_ready_r <= 1'b0;
          end
        end
        S_MUL: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= stat.ack_hit ? S_FETCH : S_PUSH;
        end
        S_FETCH: begin
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (ctrl.load_out) begin
            state_r    <= S_IDLE;
            in_ready_r <= 1'b1;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          in_ready_r <= 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/casu_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module casu_datapath #(
  parameter int SLOT_COUNT     = 72,
  parameter int DEGREE_STEP    = 10,
  parameter int MAX_REGISTERED = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire casu_pkg::casu_ctrl_t                ctrl,
  output casu_pkg::casu_stat_t                     stat,
  input  wire logic [casu_pkg::CMD_W-1:0]          in_cmd,
  input  wire logic signed [casu_pkg::DEG_W-1:0]   in_degree,
  input  wire logic [casu_pkg::COOKIE_W-1:0]       in_cookie,
  input  wire logic [casu_pkg::POS_W-1:0]          in_position,
  input  wire logic                                in_sync_bad,
  output logic      [casu_pkg::STATUS_W-1:0]       out_status,
  output logic                                     out_event_valid,
  output logic      [casu_pkg::POS_W-1:0]          out_event_slot,
  output logic      [casu_pkg::COOKIE_W-1:0]       out_event_cookie,
  output logic      [casu_pkg::POS_W-1:0]          out_current_position
);
  import casu_pkg::*;

  localparam int CYCLE = SLOT_COUNT * DEGREE_STEP;
  localparam int DW0   = $clog2(CYCLE + 1) + 1;
  localparam int DW    = (DW0 > DEG_W + 1) ? DW0 : DEG_W + 1;
  localparam int UW    = DW - 1;
  localparam int SH    = UW + $clog2(DEGREE_STEP);
  localparam int MW    = SH + 1;
  localparam int PW    = UW + MW;
  localparam int QW    = PW - SH;
  localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [MW-1:0] RECIP = MW'(((1 << SH) + DEGREE_STEP - 1) / DEGREE_STEP);
  localparam logic [POS_W:0] SLOT_LIMIT = (POS_W + 1)'(SLOT_COUNT);

  // captured item
  logic [CMD_W-1:0]    cmd_r;
  logic [COOKIE_W-1:0] cookie_r;
  logic [POS_W-1:0]    position_r;
  logic                sync_bad_r;
  logic [UW-1:0]       wrapped_r;
  logic                range_bad_r;
  logic [PW-1:0]       prod_r;

  // block state
  logic [SLOT_COUNT-1:0] occ_r, occ_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [POS_W-1:0]      pend_slot_r, pend_slot_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  halt_r, halt_nxt;

  // result
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                res_ev_valid_r, res_ev_valid_nxt;
  logic [POS_W-1:0]    res_ev_slot_r, res_ev_slot_nxt;
  logic [COOKIE_W-1:0] res_cookie_r;

  logic signed [DW-1:0] deg_ext;
  logic signed [DW-1:0] deg_wrap;
  logic [QW-1:0]        slot_q;
  logic [POS_W:0]       pos_inc;
  logic                 ram_we;
  logic [COOKIE_W-1:0]  ram_rdata;

  assign deg_ext  = {{(DW - DEG_W){in_degree[DEG_W-1]}}, in_degree};
  assign deg_wrap = (deg_ext < 0) ? deg_ext + DW'(CYCLE) : deg_ext;
  assign slot_q   = prod_r[PW-1:SH];
  assign pos_inc  = {1'b0, pos_r} + (POS_W + 1)'(1);

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r       <= in_cmd;
      cookie_r    <= in_cookie;
      position_r  <= in_position;
      sync_bad_r  <= in_sync_bad;
      wrapped_r   <= deg_wrap[UW-1:0];
      range_bad_r <= (deg_wrap < 0) || (deg_wrap >= DW'(CYCLE));
    end
    if (ctrl.multiply) begin
      prod_r <= PW'(wrapped_r) * PW'(RECIP);
    end
  end

  always_comb begin
    occ_nxt          = occ_r;
    pos_nxt          = pos_r;
    pend_v_nxt       = pend_v_r;
    pend_slot_nxt    = pend_slot_r;
    count_nxt        = count_r;
    halt_nxt         = halt_r;
    res_status_nxt   = ST_OK;
    res_ev_valid_nxt = 1'b0;
    res_ev_slot_nxt  = '0;
    ram_we           = 1'b0;
    stat.ack_hit     = 1'b0;
    if (cmd_r == CMD_INIT) begin
      occ_nxt       = '0;
      pos_nxt       = '0;
      pend_v_nxt    = 1'b0;
      pend_slot_nxt = '0;
      count_nxt     = '0;
      halt_nxt      = 1'b0;
    end else if (halt_r) begin
      res_status_nxt = ST_HALTED;
    end else begin
      case (cmd_r)
        CMD_REGISTER: begin
          if (range_bad_r || (slot_q >= QW'(SLOT_COUNT))) begin
            res_status_nxt = ST_RANGE;
          end else if (occ_r[slot_q[SW-1:0]]) begin
            res_status_nxt = ST_TAKEN;
          end else if (count_r >= CNT_W'(MAX_REGISTERED)) begin
            res_status_nxt = ST_FULL;
          end else begin
            occ_nxt[slot_q[SW-1:0]] = 1'b1;
            ram_we                  = 1'b1;
            count_nxt               = count_r + CNT_W'(1);
          end
        end
        CMD_TICK: begin
          if (({1'b0, pos_r} < SLOT_LIMIT) && occ_r[pos_r[SW-1:0]] && sync_bad_r) begin
            res_status_nxt = ST_SYNC;
          end else if (({1'b0, pos_r} < SLOT_LIMIT) && occ_r[pos_r[SW-1:0]] && pend_v_r) begin
            res_status_nxt = ST_OVERRUN;
          end else begin
            if (({1'b0, pos_r} < SLOT_LIMIT) && occ_r[pos_r[SW-1:0]]) begin
              pend_v_nxt    = 1'b1;
              pend_slot_nxt = pos_r;
            end
            pos_nxt = (pos_inc >= (POS_W + 1)'(SLOT_COUNT)) ? '0 : pos_inc[POS_W-1:0];
          end
        end
        CMD_SETPOS: begin
          if ({1'b0, position_r} >= SLOT_LIMIT) begin
            res_status_nxt = ST_POS;
          end else begin
            pos_nxt = position_r;
          end
        end
        CMD_ACK: begin
          if (!pend_v_r || ({1'b0, pend_slot_r} >= SLOT_LIMIT)) begin
            res_status_nxt = ST_NONE;
          end else begin
            stat.ack_hit     = 1'b1;
            res_ev_valid_nxt = 1'b1;
            res_ev_slot_nxt  = pend_slot_r;
            pend_v_nxt       = 1'b0;
          end
        end
        default: begin
          res_status_nxt = ST_OK;
        end
      endcase
    end
    if ((res_status_nxt >= ST_RANGE) && (res_status_nxt <= ST_OVERRUN)) begin
      halt_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      pos_r       <= '0;
      pend_v_r    <= 1'b0;
      pend_slot_r <= '0;
      count_r     <= '0;
      halt_r      <= 1'b0;
    end else if (ctrl.execute) begin
      occ_r       <= occ_nxt;
      pos_r       <= pos_nxt;
      pend_v_r    <= pend_v_nxt;
      pend_slot_r <= pend_slot_nxt;
      count_r     <= count_nxt;
      halt_r      <= halt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.execute) begin
      res_status_r   <= res_status_nxt;
      res_ev_valid_r <= res_ev_valid_nxt;
      res_ev_slot_r  <= res_ev_slot_nxt;
      res_cookie_r   <= '0;
    end
    if (ctrl.fetch) begin
      res_cookie_r <= ram_rdata;
    end
    if (ctrl.load_out) begin
      out_status           <= res_status_r;
      out_event_valid      <= res_ev_valid_r;
      out_event_slot       <= res_ev_slot_r;
      out_event_cookie     <= res_cookie_r;
      out_current_position <= pos_r;
    end
  end

  // cookie store, read at the pending slot
  casu_ram #(
    .WIDTH(COOKIE_W),
    .DEPTH(SLOT_COUNT)
  ) u_cookie_ram (
    .clk  (clk),
    .we   (ctrl.execute && ram_we),
    .waddr(slot_q[SW-1:0]),
    .wdata(cookie_r),
    .raddr(pend_slot_r[SW-1:0]),
    .rdata(ram_rdata)
  );

endmodule
`default_nettype wire

// ===== design/crank_angle_event_scheduler_unit.sv =====
// steps: after an input transfer, multiply, then execute, then push raises out_valid;
// an acknowledge that delivers an event adds a fetch (cookie memory read) before push,
// and push waits for a held result; the next input is taken after push completes
// reset: synchronous active-low rst_n clears the slot table, position, pending event,
// registry count and halt flag at once; the cookie memory is not cleared
`timescale 1ns / 1ps
`default_nettype none
module crank_angle_event_scheduler_unit #(
  parameter int SLOT_COUNT     = 72,
  parameter int DEGREE_STEP    = 10,
  parameter int MAX_REGISTERED = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [casu_pkg::CMD_W-1:0]          in_cmd,
  input  wire logic signed [casu_pkg::DEG_W-1:0]   in_degree,
  input  wire logic [casu_pkg::COOKIE_W-1:0]       in_cookie,
  input  wire logic [casu_pkg::POS_W-1:0]          in_position,
  input  wire logic                                in_sync_bad,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [casu_pkg::STATUS_W-1:0]       out_status,
  output logic                                     out_event_valid,
  output logic      [casu_pkg::POS_W-1:0]          out_event_slot,
  output logic      [casu_pkg::COOKIE_W-1:0]       out_event_cookie,
  output logic      [casu_pkg::POS_W-1:0]          out_current_position
);
  import casu_pkg::*;

  casu_ctrl_t ctrl;
  casu_stat_t stat;

  casu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  casu_datapath #(
    .SLOT_COUNT    (SLOT_COUNT),
    .DEGREE_STEP   (DEGREE_STEP),
    .MAX_REGISTERED(MAX_REGISTERED)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctrl                (ctrl),
    .stat                (stat),
    .in_cmd              (in_cmd),
    .in_degree           (in_degree),
    .in_cookie           (in_cookie),
    .in_position         (in_position),
    .in_sync_bad         (in_sync_bad),
    .out_status          (out_status),
    .out_event_valid     (out_event_valid),
    .out_event_slot      (out_event_slot),
    .out_event_cookie    (out_event_cookie),
    .out_current_position(out_current_position)
  );

  // one item in flight
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(ctrl))
    else $error("more than one sequencer step active");

  a_event_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_valid) |-> (out_status == ST_OK))
    else $error("event delivered with non-ok status");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_current_position} < (POS_W + 1)'(SLOT_COUNT)))
    else $error("position out of range");

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import casu_pkg::*;

  localparam int SLOT_COUNT     = 72;
  localparam int DEGREE_STEP    = 10;
  localparam int MAX_REGISTERED = 12;
  localparam int CYCLE_DEGREES  = SLOT_COUNT * DEGREE_STEP;
  localparam int RANDOM_ITEMS   = 1150;
  localparam int CYCLE_LIMIT    = 300000;
  localparam int DRAIN_CYCLES   = 20;

  localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                event_valid;
    logic [POS_W-1:0]    event_slot;
    logic [COOKIE_W-1:0] event_cookie;
    logic [POS_W-1:0]    current_position;
  } sched_result_t;

  class casu_scoreboard;
    bit                  occupied [SLOT_COUNT];
    logic [COOKIE_W-1:0] cookie_mem [SLOT_COUNT];
    logic [POS_W-1:0]    angle_pos;
    bit                  pend_valid;
    logic [POS_W-1:0]    pend_slot;
    int                  reg_count;
    bit                  halted;
    sched_result_t       expected_q [$];
    int                  errors;
    int                  results_seen;
    int                  events_seen;
    int                  faults_seen;

    function new();
      foreach (cookie_mem[i]) cookie_mem[i] = '0;
      clear_table();
      errors = 0;
      results_seen = 0;
      events_seen = 0;
      faults_seen = 0;
    endfunction

    function void clear_table();
      foreach (occupied[i]) occupied[i] = 1'b0;
      angle_pos = '0;
      pend_valid = 1'b0;
      pend_slot = '0;
      reg_count = 0;
      halted = 1'b0;
    endfunction

    function void note_input(logic [CMD_W-1:0] cmd, logic signed [DEG_W-1:0] degree,
                             logic [COOKIE_W-1:0] cookie, logic [POS_W-1:0] position,
                             logic sync_bad);
      sched_result_t r;
      int deg;
      int slot;
      r = '0;
      r.status = ST_OK;
      if (cmd == CMD_INIT) begin
        clear_table();
      end else if (halted) begin
        r.status = ST_HALTED;
      end else begin
        case (cmd)
          CMD_REGISTER: begin
            deg = int'(degree);
            if (deg < 0) deg = deg + CYCLE_DEGREES;
            if (deg < 0 || deg >= CYCLE_DEGREES) begin
              r.status = ST_RANGE;
            end else begin
              slot = deg / DEGREE_STEP;
              if (occupied[slot]) begin
                r.status = ST_TAKEN;
              end else if (reg_count >= MAX_REGISTERED) begin
                r.status = ST_FULL;
              end else begin
                occupied[slot] = 1'b1;
                cookie_mem[slot] = cookie;
                reg_count++;
              end
            end
          end
          CMD_TICK: begin
            if (occupied[angle_pos]) begin
              if (sync_bad) r.status = ST_SYNC;
              else if (pend_valid) r.status = ST_OVERRUN;
              else begin
                pend_valid = 1'b1;
                pend_slot = angle_pos;
              end
            end
            if (r.status == ST_OK) begin
              if (angle_pos >= SLOT_COUNT - 1) angle_pos = '0;
              else angle_pos = angle_pos + 1'b1;
            end
          end
          CMD_SETPOS: begin
            if (position >= SLOT_COUNT) r.status = ST_POS;
            else angle_pos = position;
          end
          CMD_ACK: begin
            if (!pend_valid) begin
              r.status = ST_NONE;
            end else begin
              r.event_valid = 1'b1;
              r.event_slot = pend_slot;
              r.event_cookie = cookie_mem[pend_slot];
              pend_valid = 1'b0;
            end
          end
          default: ;
        endcase
      end
      if (r.status >= ST_RANGE && r.status <= ST_OVERRUN) begin
        halted = 1'b1;
        faults_seen++;
      end
      r.current_position = angle_pos;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic event_valid,
                               logic [POS_W-1:0] event_slot, logic [COOKIE_W-1:0] event_cookie,
                               logic [POS_W-1:0] current_position);
      sched_result_t exp;
      if (expected_q.size() == 0) begin
        $error("result transfer with no expected result pending");
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      results_seen++;
      if (exp.event_valid) events_seen++;
      if (status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, status);
        errors++;
      end
      if (event_valid !== exp.event_valid) begin
        $error("event_valid: expected %0d, got %0d", exp.event_valid, event_valid);
        errors++;
      end
      if (event_slot !== exp.event_slot) begin
        $error("event_slot: expected %0d, got %0d", exp.event_slot, event_slot);
        errors++;
      end
      if (event_cookie !== exp.event_cookie) begin
        $error("event_cookie: expected %0d, got %0d", exp.event_cookie, event_cookie);
        errors++;
      end
      if (current_position !== exp.current_position) begin
        $error("current_position: expected %0d, got %0d", exp.current_position,
               current_position);
        errors++;
      end
    endfunction
  endclass

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [CMD_W-1:0]           in_cmd = '0;
  logic signed [DEG_W-1:0]    in_degree = '0;
  logic [COOKIE_W-1:0]        in_cookie = '0;
  logic [POS_W-1:0]           in_position = '0;
  logic                       in_sync_bad = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [STATUS_W-1:0]        out_status;
  logic                       out_event_valid;
  logic [POS_W-1:0]           out_event_slot;
  logic [COOKIE_W-1:0]        out_event_cookie;
  logic [POS_W-1:0]           out_current_position;

  casu_scoreboard sched_sb = new();
  bit             no_idle = 1'b0;
  int             cycle_count = 0;
  int             items_sent = 0;

  crank_angle_event_scheduler_unit #(
    .SLOT_COUNT    (SLOT_COUNT),
    .DEGREE_STEP   (DEGREE_STEP),
    .MAX_REGISTERED(MAX_REGISTERED)
  ) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (in_cmd),
    .in_degree           (in_degree),
    .in_cookie           (in_cookie),
    .in_position         (in_position),
    .in_sync_bad         (in_sync_bad),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_event_valid     (out_event_valid),
    .out_event_slot      (out_event_slot),
    .out_event_cookie    (out_event_cookie),
    .out_current_position(out_current_position)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        sched_sb.note_input(in_cmd, in_degree, in_cookie, in_position, in_sync_bad);
      end
      if (out_valid && out_ready) begin
        sched_sb.check_result(out_status, out_event_valid, out_event_slot,
                              out_event_cookie, out_current_position);
      end
    end
  end

  // result side stalls
  initial begin : result_sink
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input int degree,
                           input logic [COOKIE_W-1:0] cookie,
                           input logic [POS_W-1:0] position, input logic sync_bad);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_degree   <= DEG_W'(degree);
    in_cookie   <= cookie;
    in_position <= position;
    in_sync_bad <= sync_bad;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  initial begin : stimulus
    int  random_items;
    int  ack_pct;
    int  n_reg;
    int  n_ops;
    int  deg;
    int  slot;
    int  pick;
    int  errors;
    bit  used [SLOT_COUNT];

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_item(CMD_INIT, 0, 8'h00, 7'd0, 1'b0);
    send_item(CMD_ACK, 0, 8'h00, 7'd0, 1'b0);
    send_item(CMD_REGISTER, 0, 8'hff, 7'd0, 1'b0);
    send_item(CMD_REGISTER, 719, 8'h00, 7'd0, 1'b0);
    send_item(CMD_REGISTER, -1, 8'h12, 7'd0, 1'b0);
    send_item(CMD_TICK, 0, 8'h00, 7'd0, 1'b0);
    send_item(CMD_INIT, 0, 8'h00, 7'd0, 1'b0);
    send_item(CMD_REGISTER, -720, 8'haa, 7'd0, 1'b0);
    send_item(CMD_TICK, 0, 8'h00, 7'd0, 1'b0);
    send_item(CMD_ACK, 0, 8'h00, 7'd0, 1'b0);
    send_item(CMD_SETPOS, 0, 8'h00, 7'd71, 1'b0);
    send_item(CMD_TICK, 0, 8'h00, 7'd0, 1'b1);
    send_item(CMD_TICK, 0, 8'h00, 7'd0, 1'b1);
    send_item(CMD_INIT, 0, 8'h00, 7'd0, 1'b0);
    send_item(CMD_SETPOS, 0, 8'h00, 7'd127, 1'b0);
    send_item(CMD_INIT, 0, 8'h00, 7'd0, 1'b0);
    send_item(CMD_REGISTER, 720, 8'h01, 7'd0, 1'b0);
    send_item(CMD_INIT, 0, 8'h00, 7'd0, 1'b0);
    send_item(CMD_REGISTER, 5, 8'h5a, 7'd0, 1'b0);
    send_item(CMD_REGISTER, 10, 8'ha5, 7'd0, 1'b0);
    send_item(CMD_TICK, 0, 8'h00, 7'd0, 1'b0);
    send_item(CMD_TICK, 0, 8'h00, 7'd0, 1'b0);
    send_item(CMD_INIT, 0, 8'h00, 7'd0, 1'b0);
    send_item(CMD_RSVD_LO, -1024, 8'hff, 7'd127, 1'b1);
    send_item(CMD_RSVD_HI, 1023, 8'hff, 7'd127, 1'b1);

    // random episodes: init, registrations, then a run of ticks, acks, position sets and random commands
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      no_idle = ($urandom_range(0, 3) == 0);
      ack_pct = $urandom_range(40, 95);
      send_item(CMD_INIT, $urandom_range(0, 2047) - 1024, COOKIE_W'($urandom),
                POS_W'($urandom), 1'($urandom));
      random_items++;
      foreach (used[i]) used[i] = 1'b0;
      n_reg = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 14) : $urandom_range(1, 12);
      for (int i = 0; i < n_reg; i++) begin
        if ($urandom_range(0, 29) == 0) begin
          deg = $urandom_range(0, 2047) - 1024;
        end else begin
          do slot = $urandom_range(0, SLOT_COUNT - 1); while (used[slot]);
          used[slot] = 1'b1;
          deg = slot * DEGREE_STEP + $urandom_range(0, DEGREE_STEP - 1);
          if ($urandom_range(0, 1)) deg = deg - CYCLE_DEGREES;
        end
        send_item(CMD_REGISTER, deg, COOKIE_W'($urandom), POS_W'($urandom), 1'($urandom));
        random_items++;
      end
      n_ops = $urandom_range(30, 120);
      for (int j = 0; j < n_ops && random_items < RANDOM_ITEMS; j++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          send_item(CMD_W'($urandom_range(0, 7)), $urandom_range(0, 2047) - 1024,
                    COOKIE_W'($urandom), POS_W'($urandom), 1'($urandom));
        end else if (pick < 8) begin
          send_item(CMD_SETPOS, $urandom_range(0, 2047) - 1024, COOKIE_W'($urandom),
                    POS_W'(($urandom_range(0, 31) == 0) ? $urandom_range(SLOT_COUNT, 127)
                                                        : $urandom_range(0, SLOT_COUNT - 1)),
                    1'($urandom));
        end else begin
          send_item(CMD_TICK, $urandom_range(0, 2047) - 1024, COOKIE_W'($urandom),
                    POS_W'($urandom), ($urandom_range(0, 39) == 0));
          if ($urandom_range(0, 99) < ack_pct) begin
            send_item(CMD_ACK, $urandom_range(0, 2047) - 1024, COOKIE_W'($urandom),
                      POS_W'($urandom), 1'($urandom));
            random_items++;
          end
        end
        random_items++;
      end
    end
    in_valid <= 1'b0;

    while (sched_sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    errors = sched_sb.errors + sched_sb.expected_q.size();
    $display("%0d input transfers, %0d results checked", items_sent, sched_sb.results_seen);
    $display("%0d events delivered, %0d faults predicted", sched_sb.events_seen,
             sched_sb.faults_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
